FILE: hw/rtl/taa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package taa_pkg;

  // Angle resolution: steps per full turn and the bits that hold one angle.
  localparam int unsigned AngleSteps = 1024;
  localparam int unsigned AngleW     = $clog2(AngleSteps);

  // Default width of one vector component on the input channel.
  localparam int unsigned VecW = 16;

  // ROM entries are at most this value (an eighth of a turn).
  localparam int unsigned RomLimit = AngleSteps / 8;
  localparam int unsigned RomW     = $clog2(RomLimit) + 1;

  typedef logic [AngleW-1:0] angle_t;
  typedef logic [RomW-1:0]   rom_word_t;

endpackage

`default_nettype wire

FILE: hw/rtl/taa_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface taa_vec_if #(
  parameter int unsigned CoordW = taa_pkg::VecW
);
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] vec_x;
  logic [CoordW-1:0] vec_y;

  modport source (output valid, output vec_x, output vec_y, input ready);
  modport sink   (input valid, input vec_x, input vec_y, output ready);
endinterface

interface taa_angle_if;
  logic            valid;
  logic            ready;
  taa_pkg::angle_t angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/table_atan2_angle_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Direction of a signed (x, y) vector as an angle of 1024 steps per turn.
//
// vec_i carries one vector per transaction (vec_x, vec_y, two's complement in
// COORD_WIDTH bits); angle_o returns one angle per transaction, 0 for the
// zero vector. Both channels use valid/ready.
//
// The pipeline has one stage for magnitudes and octant, one for the constant
// multiply, one per quotient bit of the restoring divider, one for the
// registered arctangent ROM read and one for the final add and wrap into the
// output register.
// Throughput is one vector per cycle while the receiver takes results.
//
// Every stage carries a valid bit and loads when it is empty or when the
// stage after it moves, so a stalled receiver holds the result in the output
// register while empty stages upstream keep filling. vec_i.ready only drops
// once every stage holds a vector. Reset clears the valid bits; the ROM is
// fixed at elaboration and needs no fill.
module table_atan2_angle_core #(
  parameter int unsigned RATIO_STEPS = 1024,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  taa_vec_if.sink       vec_i,
  taa_angle_if.source   angle_o
);

  localparam int unsigned CW       = COORD_WIDTH;
  localparam int unsigned QW       = $clog2(RATIO_STEPS + 1);
  localparam int unsigned NW       = CW + QW;
  localparam int unsigned RomDepth = RATIO_STEPS + 2;
  localparam int unsigned IW       = $clog2(RomDepth);
  localparam int unsigned NS       = QW + 4;
  localparam int unsigned RomStage = QW + 2;
  localparam int unsigned OutStage = QW + 3;
  localparam int unsigned TrigN    = taa_pkg::RomLimit;

  localparam logic [63:0] PiQ62  = 64'hC90FDAA22168C235;
  localparam logic [63:0] OneQ62 = 64'h4000000000000000;

  localparam taa_pkg::angle_t BaseQ1 = taa_pkg::AngleW'(taa_pkg::AngleSteps / 4);
  localparam taa_pkg::angle_t BaseQ2 = taa_pkg::AngleW'(taa_pkg::AngleSteps / 2);
  localparam taa_pkg::angle_t BaseQ3 = taa_pkg::AngleW'(taa_pkg::AngleSteps * 3 / 4);
  localparam taa_pkg::angle_t BaseQ0 = '0;

  typedef taa_pkg::rom_word_t rom_t [RomDepth];

  typedef struct packed {
    logic [CW-1:0]   rem;    // partial remainder
    logic [QW-1:0]   quo;    // dividend bits still to enter, quotient bits shift in
    logic [CW-1:0]   den;    // divisor
    taa_pkg::angle_t base;
    logic            plus;
    logic            zero;
  } div_t;

  // ---------------------------------------------------------------------------
  // Arctangent ROM, built at elaboration with exact integer trig in Q62.

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // unsigned 64-bit quotient by shift and subtract
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = n;
    for (int b = 0; b < 64; b++) begin
      rem = {rem[63:0], q[63]};
      q   = {q[62:0], 1'b0};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic rom_t build_rom();
    rom_t         rom;
    logic [63:0]  sin_v [TrigN];
    logic [63:0]  cos_v [TrigN];
    logic [63:0]  step;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  s;
    logic [63:0]  c;
    logic [63:0]  t;
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic         done;
    int unsigned  dd;
    step = PiQ62 >> 9;
    for (int d = 0; d < TrigN; d++) begin
      x    = step * 64'(d);
      x2   = mul_q62(x, x);
      s    = x;
      t    = x;
      done = 1'b0;
      for (int k = 1; k < 40; k++) begin
        if (!done) begin
          t = udiv64(mul_q62(t, x2), 64'(2 * k) * 64'(2 * k + 1));
          if (t == 64'd0) done = 1'b1;
          else if (k % 2 == 1) s = s - t;
          else s = s + t;
        end
      end
      c    = OneQ62;
      t    = OneQ62;
      done = 1'b0;
      for (int k = 1; k < 40; k++) begin
        if (!done) begin
          t = udiv64(mul_q62(t, x2), 64'(2 * k - 1) * 64'(2 * k));
          if (t == 64'd0) done = 1'b1;
          else if (k % 2 == 1) c = c - t;
          else c = c + t;
        end
      end
      sin_v[d] = s;
      cos_v[d] = c;
    end
    dd = 0;
    for (int i = 0; i < RATIO_STEPS; i++) begin
      done = 1'b0;
      while (!done) begin
        if (dd >= TrigN) begin
          done = 1'b1;
        end else begin
          lhs = {64'd0, sin_v[dd]} * 128'(RATIO_STEPS);
          rhs = {64'd0, cos_v[dd]} * 128'(i);
          if (lhs >= rhs) done = 1'b1;
          else dd = dd + 1;
        end
      end
      rom[i] = taa_pkg::RomW'(dd);
    end
    rom[RATIO_STEPS]     = taa_pkg::RomW'(TrigN);
    rom[RATIO_STEPS + 1] = taa_pkg::RomW'(TrigN);
    return rom;
  endfunction

  localparam rom_t AtanRom = build_rom();

  // ---------------------------------------------------------------------------
  // Stage valid bits and load enables.

  logic [NS-1:0] valid_q;
  logic [NS:0]   ld;

  assign ld[NS] = angle_o.ready;
  for (genvar k = 0; k < NS; k++) begin : g_ld
    assign ld[k] = !valid_q[k] || ld[k+1];
  end

  assign vec_i.ready = ld[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ld[0]) valid_q[0] <= vec_i.valid;
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: magnitudes and octant.

  logic [CW-1:0]   x_in;
  logic [CW-1:0]   y_in;
  logic            nx;
  logic            ny;
  logic [CW-1:0]   mx;
  logic [CW-1:0]   my;
  logic            x_big;
  logic            zero_d;
  taa_pkg::angle_t base_d;
  logic            plus_d;

  logic [CW-1:0]   f_small_q;
  logic [CW-1:0]   f_large_q;
  taa_pkg::angle_t f_base_q;
  logic            f_plus_q;
  logic            f_zero_q;

  always_comb begin
    x_in   = vec_i.vec_x[CW-1:0];
    y_in   = vec_i.vec_y[CW-1:0];
    nx     = x_in[CW-1];
    ny     = y_in[CW-1];
    mx     = nx ? (~x_in + CW'(1)) : x_in;
    my     = ny ? (~y_in + CW'(1)) : y_in;
    x_big  = mx > my;
    zero_d = (mx == '0) && (my == '0);
    if (x_big) begin
      base_d = nx ? BaseQ3 : BaseQ1;
      plus_d = (nx == ny);
    end else if (nx) begin
      base_d = ny ? BaseQ0 : BaseQ2;  // a full turn wraps to zero
      plus_d = !ny;
    end else begin
      base_d = ny ? BaseQ0 : BaseQ2;
      plus_d = ny;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0] && vec_i.valid) begin
      f_small_q <= x_big ? my : mx;
      // zero vector divides 0 by 1 to keep the quotient in range
      f_large_q <= zero_d ? CW'(1) : (x_big ? mx : my);
      f_base_q  <= base_d;
      f_plus_q  <= plus_d;
      f_zero_q  <= zero_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: dividend small*T, then one quotient bit per stage.

  div_t          div_q [QW+1];
  logic [NW-1:0] prod;

  assign prod = NW'(f_small_q) * NW'(RATIO_STEPS);

  always_ff @(posedge clk_i) begin
    if (ld[1] && valid_q[0]) begin
      // quotient fits QW bits, so the upper part is already below the divisor
      div_q[0].rem  <= prod[NW-1:QW];
      div_q[0].quo  <= prod[QW-1:0];
      div_q[0].den  <= f_large_q;
      div_q[0].base <= f_base_q;
      div_q[0].plus <= f_plus_q;
      div_q[0].zero <= f_zero_q;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [CW:0] trial;
    logic [CW:0] diff;
    logic        ge;

    assign trial = {div_q[j].rem, div_q[j].quo[QW-1]};
    assign diff  = trial - {1'b0, div_q[j].den};
    assign ge    = trial >= {1'b0, div_q[j].den};

    always_ff @(posedge clk_i) begin
      if (ld[j+2] && valid_q[j+1]) begin
        div_q[j+1].rem  <= ge ? diff[CW-1:0] : trial[CW-1:0];
        div_q[j+1].quo  <= {div_q[j].quo[QW-2:0], ge};
        div_q[j+1].den  <= div_q[j].den;
        div_q[j+1].base <= div_q[j].base;
        div_q[j+1].plus <= div_q[j].plus;
        div_q[j+1].zero <= div_q[j].zero;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // ROM read.

  taa_pkg::rom_word_t rom_q;
  taa_pkg::angle_t    r_base_q;
  logic               r_plus_q;
  logic               r_zero_q;

  always_ff @(posedge clk_i) begin
    if (ld[RomStage] && valid_q[RomStage-1]) begin
      rom_q    <= AtanRom[IW'(div_q[QW].quo)];
      r_base_q <= div_q[QW].base;
      r_plus_q <= div_q[QW].plus;
      r_zero_q <= div_q[QW].zero;
    end
  end

  // ---------------------------------------------------------------------------
  // Add or subtract from the octant base; wraps mod one turn by width.

  taa_pkg::angle_t rom_ext;
  taa_pkg::angle_t angle_d;
  taa_pkg::angle_t angle_q;

  assign rom_ext = taa_pkg::AngleW'(rom_q);

  always_comb begin
    if (r_zero_q) angle_d = '0;
    else if (r_plus_q) angle_d = r_base_q + rom_ext;
    else angle_d = r_base_q - rom_ext;
  end

  always_ff @(posedge clk_i) begin
    if (ld[OutStage] && valid_q[OutStage-1]) begin
      angle_q <= angle_d;
    end
  end

  assign angle_o.valid = valid_q[OutStage];
  assign angle_o.angle = angle_q;

endmodule

`default_nettype wire

FILE: hw/rtl/taa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module taa_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input taa_pkg::angle_t angle_i
);

  logic       in_fire;
  logic       out_fire;
  logic [7:0] outstanding_q;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_q + 8'(in_fire) - 8'(out_fire);
    end
  end

  // a receiver that takes results never backs up the input side
  assert property (@(posedge clk_i) out_ready_i |-> in_ready_i)
    else $error("input stalled while output is being drained");

  // no result without a vector still in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (outstanding_q != 8'd0))
    else $error("result transaction without a pending input");

  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(angle_i)))
    else $error("stalled result changed or dropped");

endmodule

bind table_atan2_angle_core taa_checker u_taa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (vec_i.valid),
  .in_ready_i  (vec_i.ready),
  .out_valid_i (angle_o.valid),
  .out_ready_i (angle_o.ready),
  .angle_i     (angle_o.angle)
);

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RatioSteps  = 1024;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned LutDepth    = RatioSteps + 2;
  localparam int unsigned Latency     = $clog2(RatioSteps + 1) + 4;
  localparam int unsigned RandomItems = 1400;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned QuietLimit  = 4000;

  // pi and 1.0, both in Q62
  localparam logic [63:0] PiQ62  = 64'hC90F_DAA2_2168_C235;
  localparam logic [63:0] OneQ62 = 64'h4000_0000_0000_0000;

  localparam logic [CoordW-1:0] MaxPos = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [CoordW-1:0] MinNeg = {1'b1, {(CoordW-1){1'b0}}};

  localparam int Directed [25][2] = '{
    '{0, 0}, '{32767, 0}, '{-32768, 0}, '{0, 32767}, '{0, -32768},
    '{-32768, -32768}, '{32767, 32767}, '{-32768, 32767}, '{32767, -32768},
    '{1, 1}, '{-1, -1}, '{1, -1}, '{-1, 1},
    '{1, 0}, '{0, -1}, '{-1, 0}, '{0, 1},
    '{32767, 1}, '{1, 32767}, '{-32768, -1}, '{-1, -32768},
    '{100, 99}, '{99, 100}, '{-5, 3}, '{3, -5}
  };

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } vec_item_t;

  typedef struct packed {
    vec_item_t       vec;
    taa_pkg::angle_t angle;
  } angle_expect_t;

  typedef enum logic [1:0] {
    IdleRecvHeavy,
    IdleSendHeavy,
    IdleNone
  } idle_mode_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  taa_vec_if #(.CoordW(CoordW)) vec_if ();
  taa_angle_if angle_if ();

  table_atan2_angle_core #(
    .RATIO_STEPS(RatioSteps),
    .COORD_WIDTH(CoordW)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vec_i  (vec_if.sink),
    .angle_o(angle_if.source)
  );

  logic              drv_valid = 1'b0;
  logic [CoordW-1:0] drv_x     = '0;
  logic [CoordW-1:0] drv_y     = '0;
  logic              drv_ready = 1'b0;

  assign vec_if.valid   = drv_valid;
  assign vec_if.vec_x   = drv_x;
  assign vec_if.vec_y   = drv_y;
  assign angle_if.ready = drv_ready;

  // ---------------------------------------------------------------------------
  // Arctangent table, built the same exact way as the block's contents:
  // Q62 sine/cosine by series, then least d with sin*T >= i*cos.
  // ---------------------------------------------------------------------------
  taa_pkg::rom_word_t atan_lut [LutDepth];
  logic [63:0]        sin_tab  [taa_pkg::RomLimit];
  logic [63:0]        cos_tab  [taa_pkg::RomLimit];

  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic void build_trig_tables();
    logic [63:0] x, x2, s, c, t, div;
    for (int d = 0; d < taa_pkg::RomLimit; d++) begin
      x  = (PiQ62 >> 9) * 64'(d);
      x2 = q62_mul(x, x);
      s  = x;
      t  = x;
      for (int k = 1; k < 40; k++) begin
        div = 64'((2 * k) * (2 * k + 1));
        t   = q62_mul(t, x2) / div;
        if (t == 0) break;
        if ((k % 2) == 1) s = s - t;
        else s = s + t;
      end
      c = OneQ62;
      t = OneQ62;
      for (int k = 1; k < 40; k++) begin
        div = 64'((2 * k - 1) * (2 * k));
        t   = q62_mul(t, x2) / div;
        if (t == 0) break;
        if ((k % 2) == 1) c = c - t;
        else c = c + t;
      end
      sin_tab[d] = s;
      cos_tab[d] = c;
    end
  endfunction

  function automatic bit tan_reaches(input int unsigned d, input int unsigned i);
    logic [127:0] lhs, rhs;
    lhs = {64'd0, sin_tab[d]} * 128'(RatioSteps);
    rhs = {64'd0, cos_tab[d]} * 128'(i);
    return lhs >= rhs;
  endfunction

  function automatic void build_atan_lut();
    int unsigned d;
    d = 0;
    build_trig_tables();
    for (int unsigned i = 0; i < RatioSteps; i++) begin
      while (d < taa_pkg::RomLimit && !tan_reaches(d, i)) d++;
      atan_lut[i] = taa_pkg::rom_word_t'(d);
    end
    atan_lut[RatioSteps]     = taa_pkg::rom_word_t'(taa_pkg::RomLimit);
    atan_lut[RatioSteps + 1] = taa_pkg::rom_word_t'(taa_pkg::RomLimit);
  endfunction

  function automatic taa_pkg::angle_t predict_angle(input vec_item_t v);
    logic        nx, ny, plus;
    int unsigned ax, ay, ratio, base, r;
    nx = v.x[CoordW-1];
    ny = v.y[CoordW-1];
    ax = 32'(v.x);
    ay = 32'(v.y);
    // most negative value keeps its full magnitude
    if (nx) ax = (32'd1 << CoordW) - ax;
    if (ny) ay = (32'd1 << CoordW) - ay;
    if (ax == 0 && ay == 0) return '0;
    if (ax > ay) begin
      ratio = ay * RatioSteps / ax;
      base  = nx ? taa_pkg::AngleSteps * 3 / 4 : taa_pkg::AngleSteps / 4;
      plus  = (nx == ny);
    end else begin
      // equal magnitudes land here: ratio is full scale
      ratio = ax * RatioSteps / ay;
      if (nx) begin
        base = ny ? taa_pkg::AngleSteps : taa_pkg::AngleSteps / 2;
        plus = !ny;
      end else begin
        base = ny ? 0 : taa_pkg::AngleSteps / 2;
        plus = ny;
      end
    end
    if (ratio > LutDepth - 1) ratio = LutDepth - 1;
    r = plus ? base + atan_lut[ratio] : base - atan_lut[ratio];
    return taa_pkg::angle_t'(r % taa_pkg::AngleSteps);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, receiver, monitor
  // ---------------------------------------------------------------------------
  vec_item_t     pending_q [$];
  angle_expect_t angle_expect_q [$];

  int unsigned total_items = 0;
  int unsigned vec_sent    = 0;
  int unsigned angle_seen  = 0;
  int unsigned err_count   = 0;
  int unsigned hold_left   = 0;
  int unsigned quiet_cnt   = 0;
  logic        hold_done   = 1'b0;
  logic        vec_took    = 1'b0;
  idle_mode_t  idle_mode;

  assign idle_mode = (vec_sent < total_items / 3)     ? IdleRecvHeavy :
                     (vec_sent < 2 * total_items / 3) ? IdleSendHeavy : IdleNone;

  always @(negedge clk_i) begin
    vec_item_t   v;
    int unsigned gap_pct;
    gap_pct = (idle_mode == IdleRecvHeavy) ? 34 : (idle_mode == IdleSendHeavy) ? 47 : 0;
    if (rst_ni && (!drv_valid || vec_took)) begin
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        v = pending_q.pop_front();
        drv_x     <= v.x;
        drv_y     <= v.y;
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    int unsigned stall_pct;
    stall_pct = (idle_mode == IdleRecvHeavy) ? 47 : (idle_mode == IdleSendHeavy) ? 34 : 0;
    if (!rst_ni) begin
      drv_ready <= 1'b0;
    end else if (hold_left != 0) begin
      drv_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (idle_mode == IdleNone && !hold_done) begin
      // long back-pressure while the sender keeps offering: pipeline fills up
      drv_ready <= 1'b0;
      hold_left <= HoldCycles - 1;
      hold_done <= 1'b1;
    end else begin
      drv_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    angle_expect_t exp_item;
    vec_item_t     got_vec;
    if (rst_ni) begin
      if (angle_if.valid && angle_if.ready) begin
        angle_seen++;
        if (angle_expect_q.size() == 0) begin
          $error("angle: no transaction expected, actual %0d", angle_if.angle);
          err_count++;
        end else begin
          exp_item = angle_expect_q.pop_front();
          if (angle_if.angle !== exp_item.angle) begin
            $error("angle: expected %0d, actual %0d (vec_x %0d, vec_y %0d)",
                   exp_item.angle, angle_if.angle,
                   $signed(exp_item.vec.x), $signed(exp_item.vec.y));
            err_count++;
          end
        end
      end
      if (vec_if.valid && vec_if.ready) begin
        got_vec = '{x: vec_if.vec_x, y: vec_if.vec_y};
        angle_expect_q.push_back('{vec: got_vec, angle: predict_angle(got_vec)});
        vec_sent++;
      end
    end
    vec_took <= rst_ni && vec_if.valid && vec_if.ready;
  end

  always @(posedge clk_i) begin
    if ((vec_if.valid && vec_if.ready) || (angle_if.valid && angle_if.ready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= QuietLimit) begin
      $display("tb_top: no transaction for %0d cycles", QuietLimit);
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    vec_item_t   v;
    int unsigned kind;
    int unsigned m;

    // assert reset with an edge so the asynchronous reset fires at time zero
    rst_ni <= 1'b0;

    build_atan_lut();

    for (int i = 0; i < 25; i++) begin
      v.x = CoordW'(Directed[i][0]);
      v.y = CoordW'(Directed[i][1]);
      pending_q.push_back(v);
    end

    for (int n = 0; n < RandomItems; n++) begin
      kind = $urandom_range(0, 9);
      v.x  = CoordW'($urandom);
      v.y  = CoordW'($urandom);
      case (kind)
        4, 5: begin
          v.x = CoordW'($urandom_range(0, 32) - 16);
          v.y = CoordW'($urandom_range(0, 32) - 16);
        end
        6, 7: begin
          // magnitudes equal or one apart, random signs
          m   = $urandom_range(1, 1 << (CoordW - 1));
          v.x = CoordW'(m);
          v.y = CoordW'(m + $urandom_range(0, 2) - 1);
          if ($urandom_range(0, 1)) v.x = -v.x;
          if ($urandom_range(0, 1)) v.y = -v.y;
        end
        8: begin
          if ($urandom_range(0, 1)) v.x = '0;
          else v.y = '0;
        end
        9: begin
          v.x = $urandom_range(0, 1) ? MinNeg + CoordW'($urandom_range(0, 1))
                                     : MaxPos - CoordW'($urandom_range(0, 1));
          v.y = $urandom_range(0, 1) ? MinNeg + CoordW'($urandom_range(0, 1))
                                     : MaxPos - CoordW'($urandom_range(0, 1));
        end
        default: ;
      endcase
      pending_q.push_back(v);
    end
    total_items = pending_q.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || drv_valid) @(negedge clk_i);
    while (angle_expect_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 5) @(negedge clk_i);

    $display("tb_top: %0d vectors sent, %0d angles checked, %0d mismatches",
             vec_sent, angle_seen, err_count);
    $display("tb_top: octants, axes, zero and full-scale vectors under stalls and a %0d-cycle hold",
             HoldCycles);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
